### rtl/core/lobi_pkg.sv
// Shared types and constants for the order book insert core.
`default_nettype none
package lobi_pkg;
  localparam int LEVEL_COUNT = 256;
  localparam int ORDER_COUNT = 4096;
  localparam int LVL_W = $clog2(LEVEL_COUNT);
  localparam int ORD_W = $clog2(ORDER_COUNT);
  localparam int LNK_W = ORD_W + 1;
  localparam int VOL_W = 48;
  localparam int LVL_RW = 2 * LNK_W + VOL_W + 32;
  localparam logic [LNK_W-1:0] NIL_LINK = LNK_W'(ORDER_COUNT);
  localparam logic [VOL_W-1:0] VOL_MAX = '1;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_LEVEL_FULL = 2'd1,
    ST_STORE_FULL = 2'd2
  } add_status_t;

  typedef struct packed {
    logic        order_side;
    logic [31:0] order_price;
    logic [31:0] order_quantity;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  add_status;
    logic [7:0]  level_slot;
    logic [11:0] order_slot;
    logic [47:0] level_total;
    logic [31:0] best_bid_price;
    logic        best_bid_valid;
    logic [31:0] best_ask_price;
    logic        best_ask_valid;
  } out_item_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic              side;
    logic [31:0]       price;
    logic [31:0]       quantity;
    logic [LVL_W-1:0]  start;
  } work_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_PROBE_RD, BK_PROBE_CHK, BK_SCAN_CHK, BK_LINK,
    BK_BEST_RD, BK_BEST_CHK, BK_DONE
  } bk_state_t;
endpackage
`default_nettype wire

### rtl/core/lobi_front.sv
// Front end: accept requests, compute hash start index, feed a two-entry queue.
`default_nettype none
module lobi_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  lobi_pkg::in_item_t       in_data,
  output logic                     wk_valid,
  input  wire                      wk_ready,
  output lobi_pkg::work_t          wk_data
);
  import lobi_pkg::*;
  work_t q [2];
  logic [1:0] count;
  logic rd_ptr, wr_ptr;
  logic [31:0] mag;
  work_t nw;
  logic push, pop;

  always_comb begin
    mag = in_data.order_price[31] ? (32'd0 - in_data.order_price) : in_data.order_price;
    nw.side = in_data.order_side;
    nw.price = in_data.order_price;
    nw.quantity = in_data.order_quantity;
    nw.start = mag[LVL_W-1:0];
  end

  assign in_ready = (count != 2'd2);
  assign wk_valid = (count != 2'd0);
  assign wk_data = q[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = wk_valid && wk_ready;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= nw;
    if (rst) begin
      count <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### rtl/core/lobi_back.sv
// Back end: level probe, free-slot check, FIFO append, best-price sweep.
`default_nettype none
module lobi_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  wk_valid,
  output logic                 wk_ready,
  input  lobi_pkg::work_t      wk_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output lobi_pkg::out_item_t  out_data
);
  import lobi_pkg::*;

  logic [LEVEL_COUNT-1:0] act [2];
  logic [LVL_RW-1:0] lvl_mem [2*LEVEL_COUNT];
  logic [LVL_RW-1:0] lvl_rd;
  logic [LNK_W-1:0] onext_mem [ORDER_COUNT];
  logic [LNK_W-1:0] oprev_mem [ORDER_COUNT];
  logic [64:0] orec_mem [ORDER_COUNT];

  bk_state_t state, state_next;
  work_t cur;
  logic [LVL_W:0] cnt;
  logic [ORD_W:0] ofill;
  logic [LVL_W-1:0] idx, lvl;
  logic [ORD_W-1:0] fptr, slot;
  logic side_b;
  logic [31:0] l_price;
  logic [VOL_W-1:0] l_vol, vol_new;
  logic [LNK_W-1:0] l_head, l_tail;
  logic [31:0] bb, ba;
  logic bbv, bav;
  logic rd_act;
  logic [VOL_W:0] vsum;
  logic probe_hit, probe_last, store_full, sweep_last, sweep_go, lvl_empty;
  out_item_t res;

  assign l_price = lvl_rd[31:0];
  assign l_vol = lvl_rd[32 +: VOL_W];
  assign l_tail = lvl_rd[32+VOL_W +: LNK_W];
  assign l_head = lvl_rd[32+VOL_W+LNK_W +: LNK_W];
  assign vsum = {1'b0, l_vol} + {{(VOL_W-31){1'b0}}, cur.quantity};
  assign vol_new = vsum[VOL_W] ? VOL_MAX : vsum[VOL_W-1:0];
  assign lvl_empty = (l_head >= NIL_LINK) || (l_tail >= NIL_LINK);

  assign probe_hit = !rd_act || (l_price == cur.price);
  assign probe_last = (cnt == (LVL_W+1)'(LEVEL_COUNT - 1));
  assign sweep_last = (cnt == (LVL_W+1)'(2 * LEVEL_COUNT - 1));
  // Slots are never released, so the free-slot check takes the slot at the pointer
  // unless every slot is taken.
  assign store_full = (ofill == (ORD_W+1)'(ORDER_COUNT));
  assign sweep_go = (state == BK_LINK) || (state == BK_SCAN_CHK && store_full) ||
                    (state == BK_PROBE_CHK && !probe_hit && probe_last);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:      if (wk_valid) state_next = BK_PROBE_RD;
      BK_PROBE_RD:  state_next = BK_PROBE_CHK;
      BK_PROBE_CHK: begin
        if (probe_hit) state_next = BK_SCAN_CHK;
        else if (probe_last) state_next = BK_BEST_RD;
        else state_next = BK_PROBE_RD;
      end
      BK_SCAN_CHK: begin
        if (!store_full) state_next = BK_LINK;
        else state_next = BK_BEST_RD;
      end
      BK_LINK:      state_next = BK_BEST_RD;
      BK_BEST_RD:   state_next = BK_BEST_CHK;
      BK_BEST_CHK: begin
        if (sweep_last) state_next = BK_DONE;
        else state_next = BK_BEST_RD;
      end
      BK_DONE:      if (out_ready) state_next = BK_IDLE;
      default:      state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    wk_ready = (state == BK_IDLE);
    out_valid = (state == BK_DONE);
    out_data = res;
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (wk_valid) begin
          cur <= wk_data;
          idx <= wk_data.start;
          cnt <= '0;
          res.add_status <= ST_LEVEL_FULL;
          res.level_slot <= '0;
          res.order_slot <= '0;
          res.level_total <= '0;
        end
      end
      BK_PROBE_RD: begin
        lvl_rd <= lvl_mem[{cur.side, idx}];
        rd_act <= act[cur.side][idx];
      end
      BK_PROBE_CHK: begin
        if (probe_hit) begin
          lvl <= idx;
          cnt <= '0;
          res.level_slot <= 8'(idx);
          res.add_status <= ST_STORE_FULL;
          res.level_total <= rd_act ? l_vol : '0;
          if (!rd_act) begin
            lvl_rd <= {NIL_LINK, NIL_LINK, {VOL_W{1'b0}}, cur.price};
            lvl_mem[{cur.side, idx}] <= {NIL_LINK, NIL_LINK, {VOL_W{1'b0}}, cur.price};
          end
        end else begin
          idx <= idx + 1'b1;
          cnt <= probe_last ? '0 : cnt + 1'b1;
        end
      end
      BK_SCAN_CHK: begin
        if (!store_full) begin
          slot <= fptr;
          oprev_mem[fptr] <= l_tail;
          onext_mem[fptr] <= NIL_LINK;
        end
      end
      BK_LINK: begin
        res.add_status <= ST_ADDED;
        res.order_slot <= 12'(slot);
        res.level_total <= vol_new;
        orec_mem[slot] <= {cur.side, cur.price, cur.quantity};
        if (!lvl_empty) onext_mem[l_tail[ORD_W-1:0]] <= {1'b0, slot};
        lvl_mem[{cur.side, lvl}] <= {
          (lvl_empty ? {1'b0, slot} : l_head),
          {1'b0, slot},
          vol_new,
          l_price};
      end
      BK_BEST_RD: begin
        side_b <= cnt[LVL_W];
        rd_act <= act[cnt[LVL_W]][cnt[LVL_W-1:0]];
        lvl_rd <= lvl_mem[cnt[LVL_W:0]];
      end
      BK_BEST_CHK: begin
        cnt <= cnt + 1'b1;
        if (rd_act) begin
          if (!side_b && (!bbv || $signed(l_price) > $signed(bb))) begin
            bb <= l_price;
            bbv <= 1'b1;
          end
          if (side_b && (!bav || $signed(l_price) < $signed(ba))) begin
            ba <= l_price;
            bav <= 1'b1;
          end
        end
        if (sweep_last) begin
          res.best_bid_price <= (rd_act && !side_b && (!bbv || $signed(l_price) > $signed(bb)))
                                ? l_price : bb;
          res.best_bid_valid <= bbv || (rd_act && !side_b);
          res.best_ask_price <= (rd_act && side_b && (!bav || $signed(l_price) < $signed(ba)))
                                ? l_price : ba;
          res.best_ask_valid <= bav || (rd_act && side_b);
        end
      end
      default: ;
    endcase
    if (sweep_go) begin
      bbv <= 1'b0;
      bav <= 1'b0;
      bb <= '0;
      ba <= '0;
    end
    if (rst) begin
      state <= BK_IDLE;
      act[0] <= '0;
      act[1] <= '0;
      ofill <= '0;
      fptr <= '0;
    end else begin
      state <= state_next;
      if (state == BK_PROBE_CHK && !rd_act) act[cur.side][idx] <= 1'b1;
      if (state == BK_SCAN_CHK && !store_full) begin
        ofill <= ofill + 1'b1;
        fptr <= fptr + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/limit_order_book_insert_core.sv
// Top level of the order book insert core.
// Per order: a read and a check per level probe, then a free-slot check unless no level
// matched, a link step unless the order store is full, a best-price sweep over both level
// tables and the handoff. One order at a time; the next is accepted in the cycle after the
// result is taken, and a two-entry request queue absorbs input meanwhile.
// Synchronous reset clears the level valid bits, the order fill count and the scan pointer.
`default_nettype none
module limit_order_book_insert_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  lobi_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output lobi_pkg::out_item_t  out_data
);
  import lobi_pkg::*;
  logic wk_valid, wk_ready;
  work_t wk_data;

  lobi_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .wk_valid, .wk_ready, .wk_data
  );

  lobi_back u_back (
    .clk, .rst, .wk_valid, .wk_ready, .wk_data,
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire
